// ===== hdl/bccs_pkg.sv =====
// Package for the binary chain cluster statistics block.
// Holds field widths, register addresses, reset values and the result record type.
// No dependencies.
package bccs_pkg;

  localparam int unsigned MaxSitesDef   = 64;
  localparam int unsigned PatternW      = 64;
  localparam int unsigned CountW        = 7;
  localparam int unsigned IndexW        = 6;
  localparam int unsigned RunW          = 6;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned FillW         = FracBits + 1;
  localparam int unsigned DivSteps      = FracBits + 1;
  localparam int unsigned OutDataW      = 56;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  // Register index, taken from paddr[2] (registers sit 4 bytes apart).
  localparam logic RegChainLength = 1'b0;

  localparam logic [CountW-1:0] ChainLengthReset = 7'd64;

  // Statistics of one item as they travel down the pipeline.
  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [IndexW-1:0] first;
    logic [IndexW-1:0] last;
    logic [CountW-1:0] span;
    logic [RunW-1:0]   runs;
    logic              single;
    logic              empty;
  } res_t;

endpackage

// ===== hdl/binary_chain_cluster_stats.sv =====
// Top level of the binary chain cluster statistics block.
// Depends on bccs_pkg for widths, register addresses and the result record.
//
// Usage:
//   Each item on the slave stream carries one 64-bit occupation pattern; only
//   the low chain_length sites (capped at MAX_SITES) are looked at. Each item
//   gives exactly one result item on the master stream: active count, first
//   and last active site, span, run count, single-run flag, fill ratio
//   (count/span, 16 fraction bits, truncated) and an empty flag.
//   chain_length is written over the APB port at byte address 0; the user must
//   write it only while the block is idle, as the block does not enforce this. It resets to 64.
//   The result is registered through these stages: one stage
//   masks the pattern, two stages reduce it in groups of eight sites, one
//   forms the span, and a 17-stage restoring divider produces one quotient
//   bit per stage. One item is accepted every cycle while the master stream is not stalled.
//   Reset empties the pipeline. When the receiver stalls, each stage holds
//   only while the stage after it is full, so empty slots close up and the
//   block keeps accepting until all 21 stages hold an item.
module binary_chain_cluster_stats
  import bccs_pkg::*;
#(
  parameter int unsigned MAX_SITES = MaxSitesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave stream. tdata: pattern[63:0].
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PatternW-1:0] s_axis_tdata,
  // Master stream. tdata, low bit up: active_count[6:0], first_active[12:7],
  // last_active[18:13], span[25:19], run_count[31:26], single_run[32],
  // fill_ratio[49:33], is_empty[50], zero fill[55:51].
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // APB configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned NGrp = (MAX_SITES + 7) / 8;
  localparam int unsigned PadW = NGrp * 8;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  function automatic logic [2:0] lsb8(input logic [7:0] b);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Configuration register.
  logic [CountW-1:0] chain_length_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegChainLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_length_q <= ChainLengthReset;
    end else if (cfg_wr) begin
      chain_length_q <= pwdata[CountW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegChainLength) prdata = ApbDataW'(chain_length_q);
  end

  // Stage flow control: a stage loads when it is empty or its contents move on.
  logic              v0_q, v1_q, v2_q, v3_q;
  logic              en0, en1, en2, en3;
  logic [DivSteps-1:0] dv_q;
  logic [DivSteps-1:0] en_div;

  always_comb begin
    for (int k = DivSteps - 1; k >= 0; k--) begin
      if (k == DivSteps - 1) en_div[k] = !dv_q[k] || m_axis_tready;
      else                   en_div[k] = !dv_q[k] || en_div[k+1];
    end
    en3 = !v3_q || en_div[0];
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
    en0 = !v0_q || en1;
  end

  assign s_axis_tready = en0;

  // Stage 0: keep the sites in use.
  logic [CountW-1:0]    len;
  logic [MAX_SITES-1:0] site_mask;
  logic [MAX_SITES-1:0] m0_q;

  always_comb begin
    len = (chain_length_q > CountW'(MAX_SITES)) ? CountW'(MAX_SITES) : chain_length_q;
    for (int i = 0; i < MAX_SITES; i++) begin
      site_mask[i] = (CountW'(i) < len);
    end
  end

  // Stage 1: per-group counts and edge positions.
  logic [PadW-1:0] m_pad, s_pad;
  logic [3:0]      gcnt_q [NGrp];
  logic [3:0]      grun_q [NGrp];
  logic [2:0]      glo_q  [NGrp];
  logic [2:0]      ghi_q  [NGrp];
  logic [NGrp-1:0] gany_q;

  // A run starts at every active site whose lower neighbour is inactive.
  assign m_pad = PadW'(m0_q);
  assign s_pad = PadW'(m0_q & ~{m0_q[MAX_SITES-2:0], 1'b0});

  // Stage 2: whole-pattern reduction.
  logic [CountW-1:0] cnt2_d, cnt2_q;
  logic [RunW-1:0]   runs2_d, runs2_q;
  logic [IndexW-1:0] first2_d, first2_q;
  logic [IndexW-1:0] last2_d, last2_q;
  logic              empty2_q;

  always_comb begin
    cnt2_d   = '0;
    runs2_d  = '0;
    first2_d = '0;
    last2_d  = '0;
    for (int g = 0; g < NGrp; g++) begin
      cnt2_d  = cnt2_d + CountW'(gcnt_q[g]);
      runs2_d = runs2_d + RunW'(grun_q[g]);
      if (gany_q[g]) last2_d = IndexW'(g * 8) + IndexW'(ghi_q[g]);
    end
    for (int g = NGrp - 1; g >= 0; g--) begin
      if (gany_q[g]) first2_d = IndexW'(g * 8) + IndexW'(glo_q[g]);
    end
  end

  // Stage 3: span and flags.
  res_t res3_d, res3_q;

  always_comb begin
    res3_d.cnt    = cnt2_q;
    res3_d.first  = first2_q;
    res3_d.last   = last2_q;
    res3_d.runs   = runs2_q;
    res3_d.single = (runs2_q == RunW'(1));
    res3_d.empty  = empty2_q;
    res3_d.span   = empty2_q ? '0
                  : CountW'(last2_q) - CountW'(first2_q) + CountW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && s_axis_tvalid) m0_q <= s_axis_tdata[MAX_SITES-1:0] & site_mask;
    if (en1 && v0_q) begin
      for (int g = 0; g < NGrp; g++) begin
        gcnt_q[g] <= popcnt8(m_pad[g*8 +: 8]);
        grun_q[g] <= popcnt8(s_pad[g*8 +: 8]);
        glo_q[g]  <= lsb8(m_pad[g*8 +: 8]);
        ghi_q[g]  <= msb8(m_pad[g*8 +: 8]);
        gany_q[g] <= |m_pad[g*8 +: 8];
      end
    end
    if (en2 && v1_q) begin
      cnt2_q   <= cnt2_d;
      runs2_q  <= runs2_d;
      first2_q <= first2_d;
      last2_q  <= last2_d;
      empty2_q <= ~|gany_q;
    end
    if (en3 && v2_q) res3_q <= res3_d;
  end

  // Divider: restoring division of cnt * 2^16 by span, one quotient bit per
  // stage, most significant first. As cnt never exceeds span, the first step
  // starts from cnt itself and every later step shifts in a zero.
  logic [CountW-1:0] rem_q [DivSteps];
  logic [CountW-1:0] rem_d [DivSteps];
  logic [FillW-1:0]  quo_q [DivSteps];
  logic [FillW-1:0]  quo_d [DivSteps];
  res_t              res_q [DivSteps];
  res_t              res_d [DivSteps];
  logic [DivSteps-1:0] dv_in;

  always_comb begin
    logic [CountW:0] part;
    logic            ge;
    for (int k = 0; k < DivSteps; k++) begin
      if (k == 0) begin
        res_d[k] = res3_q;
        dv_in[k] = v3_q;
        part     = {1'b0, res3_q.cnt};
      end else begin
        res_d[k] = res_q[k-1];
        dv_in[k] = dv_q[k-1];
        part     = {rem_q[k-1], 1'b0};
      end
      ge       = (part >= {1'b0, res_d[k].span});
      rem_d[k] = ge ? CountW'(part - {1'b0, res_d[k].span}) : CountW'(part);
      if (k == 0) quo_d[k] = FillW'(ge);
      else        quo_d[k] = {quo_q[k-1][FillW-2:0], ge};
      // An empty pattern has no span; its ratio is zero.
      if (k == DivSteps - 1 && res_d[k].empty) quo_d[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      for (int k = 0; k < DivSteps; k++) begin
        if (en_div[k]) dv_q[k] <= dv_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivSteps; k++) begin
      if (en_div[k] && dv_in[k]) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        res_q[k] <= res_d[k];
      end
    end
  end

  // Output item straight from the last divider stage.
  res_t res_out;
  assign res_out       = res_q[DivSteps-1];
  assign m_axis_tvalid = dv_q[DivSteps-1];
  assign m_axis_tdata  = {5'b0, res_out.empty, quo_q[DivSteps-1], res_out.single,
                          res_out.runs, res_out.span, res_out.last, res_out.first,
                          res_out.cnt};

endmodule
